### rtl/dacm_pkg.sv
package dacm_pkg;

   localparam int ACTION_W = 2;
   localparam int INDEX_W  = 12;
   localparam int BITN_W   = 5;
   localparam int WEIGHT_W = 21;
   localparam int MASK_W   = 48;
   localparam int HALF_W   = 24;
   localparam int OUT_PAT_W = 18;

   // internal widths sized for the largest parameter values
   localparam int MAX_FRAC = 16;
   localparam int TGT_W    = INDEX_W + 1 + MAX_FRAC;
   localparam int SUM_W    = TGT_W + 1;
   localparam int PAT_W    = 32;

   localparam logic [ACTION_W-1:0] ACT_CONVERT     = 2'd0;
   localparam logic [ACTION_W-1:0] ACT_LOAD_WEIGHT = 2'd1;
   localparam logic [ACTION_W-1:0] ACT_LOAD_MASK   = 2'd2;

   localparam int DEF_NUM_WEIGHTS = 18;
   localparam int DEF_FRAC_BITS   = 8;
   localparam int DEF_CODE_WIDTH  = 48;
   localparam int DEF_INDEX_MAX   = 4095;

   typedef struct packed {
      logic [ACTION_W-1:0] action;
      logic [INDEX_W-1:0]  code_index;
      logic [BITN_W-1:0]   bit_number;
      logic [WEIGHT_W-1:0] weight_value;
      logic [MASK_W-1:0]   mask_value;
   } req_type;

   typedef struct packed {
      logic [HALF_W-1:0]    code_low;
      logic [HALF_W-1:0]    code_high;
      logic [OUT_PAT_W-1:0] bit_pattern;
   } rsp_type;

   // item as it travels down the chain of cells
   typedef struct packed {
      logic [ACTION_W-1:0] action;
      logic [BITN_W-1:0]   bitn;
      logic [WEIGHT_W-1:0] weight;
      logic [MASK_W-1:0]   mask;
      logic [TGT_W-1:0]    target;
      logic [SUM_W-1:0]    sum;
      logic [MASK_W-1:0]   code;
      logic [PAT_W-1:0]    pattern;
   } tok_type;

endpackage

### rtl/dacm_cell.sv
module dacm_cell #(
   parameter int BIT_INDEX = 0
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              in_valid,
   output logic              in_ready,
   input  dacm_pkg::tok_type in_tok,
   output logic              out_valid,
   input  logic              out_ready,
   output dacm_pkg::tok_type out_tok
);

   logic [dacm_pkg::WEIGHT_W-1:0] weight_ff;
   logic [dacm_pkg::MASK_W-1:0]   mask_ff;
   logic                          valid_ff;
   logic                          valid_in;
   dacm_pkg::tok_type             tok_ff;
   dacm_pkg::tok_type             tok_in;
   logic                          take;
   logic                          hit;
   logic [dacm_pkg::SUM_W-1:0]    trial;
   logic                          keep;

   assign in_ready  = !valid_ff || out_ready;
   assign take      = in_valid && in_ready;
   assign out_valid = valid_ff;
   assign out_tok   = tok_ff;
   assign hit       = (in_tok.bitn == dacm_pkg::BITN_W'(BIT_INDEX));

   assign trial = in_tok.sum + dacm_pkg::SUM_W'(weight_ff);
   assign keep  = (trial <= dacm_pkg::SUM_W'(in_tok.target));

   always_comb begin
      tok_in   = in_tok;
      valid_in = valid_ff;
      if (take) begin
         valid_in = 1'b1;
      end else if (out_ready) begin
         valid_in = 1'b0;
      end
      if (in_tok.action == dacm_pkg::ACT_CONVERT && keep) begin
         tok_in.sum                = trial;
         tok_in.code               = in_tok.code | mask_ff;
         tok_in.pattern[BIT_INDEX] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff  <= 1'b0;
         weight_ff <= '0;
         mask_ff   <= '0;
      end else begin
         valid_ff <= valid_in;
         if (take && hit && in_tok.action == dacm_pkg::ACT_LOAD_WEIGHT) begin
            weight_ff <= in_tok.weight;
         end
         if (take && hit && in_tok.action == dacm_pkg::ACT_LOAD_MASK) begin
            mask_ff <= in_tok.mask;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         tok_ff <= tok_in;
      end
   end

endmodule

### rtl/weighted_dac_code_mapper.sv
// Weighted DAC code mapper.
// req channel: req_valid / req_stall / req_item. An item is either a convert
// (code_index), a weight load or a mask load (bit_number selects the bit).
// rsp channel: rsp_valid / rsp_stall / rsp_item; one item per convert, none
// for loads or the unused action code.
// csr port: csr_wr_en / csr_wr_data writes zero_offset; write only when idle.
// Each weighted bit lives in one cell of a chain, highest bit first. Every item,
// loads included, walks the chain one cell per cycle when not stalled, so
// loads and converts keep their order. One item per cycle is accepted while
// req_stall is low, set by the one-cell-per-cycle chain.
// A stalled result is held in the output register; items behind it keep
// moving into empty cells, and req_stall rises only once the first cell is
// full and cannot move.
// Synchronous reset clears all weights, masks, zero_offset and every valid.
module weighted_dac_code_mapper #(
   parameter int NUM_WEIGHTS = dacm_pkg::DEF_NUM_WEIGHTS,
   parameter int FRAC_BITS   = dacm_pkg::DEF_FRAC_BITS,
   parameter int CODE_WIDTH  = dacm_pkg::DEF_CODE_WIDTH,
   parameter int INDEX_MAX   = dacm_pkg::DEF_INDEX_MAX
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_stall,
   input  dacm_pkg::req_type            req_item,
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output dacm_pkg::rsp_type            rsp_item,
   input  logic                         csr_wr_en,
   input  logic [dacm_pkg::INDEX_W-1:0] csr_wr_data
);

   localparam logic [dacm_pkg::MASK_W-1:0] CODE_MASK =
      (CODE_WIDTH >= dacm_pkg::MASK_W) ? {dacm_pkg::MASK_W{1'b1}} :
      ((dacm_pkg::MASK_W'(1) << CODE_WIDTH) - dacm_pkg::MASK_W'(1));

   logic [dacm_pkg::INDEX_W-1:0] zero_offset_ff;
   logic [dacm_pkg::INDEX_W-1:0] idx_sat;
   logic [dacm_pkg::INDEX_W:0]   idx_sum;
   logic                         v   [0:NUM_WEIGHTS];
   logic                         rdy [0:NUM_WEIGHTS];
   dacm_pkg::tok_type            t   [0:NUM_WEIGHTS];
   logic                         tail_convert;
   logic                         rsp_valid_ff;
   logic                         rsp_valid_in;
   dacm_pkg::rsp_type            rsp_item_ff;
   logic [dacm_pkg::MASK_W-1:0]  code_final;

   always_ff @(posedge clock) begin
      if (reset) begin
         zero_offset_ff <= '0;
      end else if (csr_wr_en) begin
         zero_offset_ff <= csr_wr_data;
      end
   end

   assign idx_sat = ({5'd0, req_item.code_index} > 17'(INDEX_MAX)) ?
                    dacm_pkg::INDEX_W'(INDEX_MAX) : req_item.code_index;
   assign idx_sum = {1'b0, idx_sat} + {1'b0, zero_offset_ff};

   always_comb begin
      t[0]        = '0;
      t[0].action = req_item.action;
      t[0].bitn   = req_item.bit_number;
      t[0].weight = req_item.weight_value;
      t[0].mask   = req_item.mask_value;
      t[0].target = dacm_pkg::TGT_W'(idx_sum) << FRAC_BITS;
   end

   assign v[0]      = req_valid;
   assign req_stall = !rdy[0];

   for (genvar k = 0; k < NUM_WEIGHTS; k++) begin : g_cell
      dacm_cell #(
         .BIT_INDEX(NUM_WEIGHTS - 1 - k)
      ) u_cell (
         .clock    (clock),
         .reset    (reset),
         .in_valid (v[k]),
         .in_ready (rdy[k]),
         .in_tok   (t[k]),
         .out_valid(v[k+1]),
         .out_ready(rdy[k+1]),
         .out_tok  (t[k+1])
      );
   end

   assign tail_convert = (t[NUM_WEIGHTS].action == dacm_pkg::ACT_CONVERT);
   assign rdy[NUM_WEIGHTS] = !tail_convert || !rsp_valid_ff || !rsp_stall;
   assign code_final = t[NUM_WEIGHTS].code & CODE_MASK;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (v[NUM_WEIGHTS] && tail_convert && rdy[NUM_WEIGHTS]) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (v[NUM_WEIGHTS] && tail_convert && rdy[NUM_WEIGHTS]) begin
         rsp_item_ff.code_low    <= code_final[dacm_pkg::HALF_W-1:0];
         rsp_item_ff.code_high   <= code_final[dacm_pkg::MASK_W-1:dacm_pkg::HALF_W];
         rsp_item_ff.bit_pattern <= dacm_pkg::OUT_PAT_W'(t[NUM_WEIGHTS].pattern);
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_item_ff;

   a_reset_clears: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid after reset");

   a_stall_only_when_full: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> v[1])
      else $error("input stalled with empty first cell");

   a_result_from_convert: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !$past(rsp_valid && rsp_stall)) |->
      $past(v[NUM_WEIGHTS] && tail_convert))
      else $error("result without a convert at the chain tail");

   a_pattern_range: assert property (@(posedge clock) disable iff (reset)
      v[NUM_WEIGHTS] |-> ((t[NUM_WEIGHTS].pattern >> NUM_WEIGHTS) == '0))
      else $error("kept bit beyond the weight count");

endmodule

### tb/sv/tb_weighted_dac_code_mapper.sv
module tb_weighted_dac_code_mapper;
   timeunit 1ns;
   timeprecision 1ps;

   import dacm_pkg::*;

   localparam int NUM_W      = DEF_NUM_WEIGHTS;
   localparam int LATENCY    = NUM_W + 1;
   localparam int IDLE_LIMIT = 1000;
   localparam int PHASES     = 6;
   localparam int MIXED_N    = 80;
   localparam int DIR_N      = 25;
   localparam int REPORT_MAX = 10;

   localparam logic [ACTION_W-1:0] ACT_UNUSED = 2'd3;

   localparam int FIB [NUM_W] = '{1, 2, 3, 5, 8, 13, 21, 34, 55, 89, 144, 233, 377, 610,
                                  987, 1597, 2584, 4181};

   typedef struct packed {
      req_type req;
      logic    known;
      rsp_type rsp;
   } dir_row_type;

   localparam rsp_type NONE = '{24'h0, 24'h0, 18'h0};

   localparam dir_row_type DIR_ROWS [DIR_N] = '{
      '{'{ACT_CONVERT, 12'd0, 5'd0, 21'd0, 48'd0}, 1'b1, '{24'h0, 24'h0, 18'h3FFFF}},
      '{'{ACT_CONVERT, 12'd4095, 5'd31, 21'h1FFFFF, 48'hFFFF_FFFF_FFFF}, 1'b1,
        '{24'h0, 24'h0, 18'h3FFFF}},
      '{'{ACT_LOAD_MASK, 12'd0, 5'd17, 21'd0, 48'hFFFF_FFFF_FFFF}, 1'b0, NONE},
      '{'{ACT_CONVERT, 12'd0, 5'd0, 21'd0, 48'd0}, 1'b1,
        '{24'hFFFFFF, 24'hFFFFFF, 18'h3FFFF}},
      '{'{ACT_LOAD_WEIGHT, 12'd0, 5'd17, 21'h1FFFFF, 48'd0}, 1'b0, NONE},
      '{'{ACT_CONVERT, 12'd4095, 5'd0, 21'd0, 48'd0}, 1'b1, '{24'h0, 24'h0, 18'h1FFFF}},
      '{'{ACT_LOAD_WEIGHT, 12'd0, 5'd0, 21'h000100, 48'd0}, 1'b0, NONE},
      '{'{ACT_CONVERT, 12'd0, 5'd0, 21'd0, 48'd0}, 1'b1, '{24'h0, 24'h0, 18'h1FFFE}},
      '{'{ACT_LOAD_MASK, 12'd0, 5'd0, 21'd0, 48'h0000_0000_0001}, 1'b0, NONE},
      '{'{ACT_CONVERT, 12'd1, 5'd0, 21'd0, 48'd0}, 1'b1, '{24'h000001, 24'h0, 18'h1FFFF}},
      '{'{ACT_UNUSED, 12'hFFF, 5'd31, 21'h1FFFFF, 48'hFFFF_FFFF_FFFF}, 1'b0, NONE},
      '{'{ACT_LOAD_WEIGHT, 12'd0, 5'd31, 21'd0, 48'd0}, 1'b0, NONE},
      '{'{ACT_LOAD_MASK, 12'd0, 5'd18, 21'd0, 48'hFFFF_FFFF_FFFF}, 1'b0, NONE},
      '{'{ACT_CONVERT, 12'd0, 5'd0, 21'd0, 48'd0}, 1'b0, NONE},
      '{'{ACT_LOAD_WEIGHT, 12'd0, 5'd17, 21'd0, 48'd0}, 1'b0, NONE},
      '{'{ACT_LOAD_MASK, 12'd0, 5'd17, 21'd0, 48'h5555_55AA_AAAA}, 1'b0, NONE},
      '{'{ACT_LOAD_WEIGHT, 12'd0, 5'd16, 21'h100000, 48'd0}, 1'b0, NONE},
      '{'{ACT_LOAD_WEIGHT, 12'd0, 5'd15, 21'h0FFFFF, 48'd0}, 1'b0, NONE},
      '{'{ACT_LOAD_MASK, 12'd0, 5'd16, 21'd0, 48'hAAAA_AA55_5555}, 1'b0, NONE},
      '{'{ACT_CONVERT, 12'd4095, 5'd0, 21'd0, 48'd0}, 1'b0, NONE},
      '{'{ACT_CONVERT, 12'd2048, 5'd0, 21'd0, 48'd0}, 1'b0, NONE},
      '{'{ACT_LOAD_WEIGHT, 12'd0, 5'd1, 21'h0000FF, 48'd0}, 1'b0, NONE},
      '{'{ACT_CONVERT, 12'd1, 5'd0, 21'd0, 48'd0}, 1'b0, NONE},
      '{'{ACT_CONVERT, 12'd4094, 5'd0, 21'd0, 48'd0}, 1'b0, NONE},
      '{'{ACT_CONVERT, 12'd555, 5'd0, 21'd0, 48'd0}, 1'b0, NONE}
   };

   logic                clock;
   logic                reset       = 1'b1;
   logic                req_valid   = 1'b0;
   logic                req_stall;
   req_type             req_item    = '0;
   logic                rsp_valid;
   logic                rsp_stall   = 1'b0;
   rsp_type             rsp_item;
   logic                csr_wr_en   = 1'b0;
   logic [INDEX_W-1:0]  csr_wr_data = '0;

   // expectation that travels with the item on the bus
   logic                item_known  = 1'b0;
   rsp_type             item_rsp    = '0;

   logic                rsp_idle_on = 1'b1;
   logic                req_gaps    = 1'b1;
   int                  stall_left  = 0;

   logic [WEIGHT_W-1:0] weight_tbl [NUM_W];
   logic [MASK_W-1:0]   mask_tbl [NUM_W];
   logic [INDEX_W-1:0]  zero_off;
   rsp_type             pending_codes [$];
   rsp_type             want;
   logic                req_fire;
   logic                rsp_fire;
   int                  idle_cycles = 0;
   int                  fault_cnt   = 0;

   weighted_dac_code_mapper uut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_item    (req_item),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_item    (rsp_item),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   always begin
      clock = 1'b0;
      #10;
      clock = 1'b1;
      #10;
   end

   // greedy decomposition, highest weight first
   function automatic rsp_type map_code(input logic [INDEX_W-1:0] idx);
      logic [20:0]       goal;
      logic [22:0]       acc;
      logic [22:0]       trial;
      logic [MASK_W-1:0] code;
      logic [17:0]       pat;
      rsp_type           r;
      int                i;
      goal = {5'd0, idx} + {5'd0, zero_off};
      goal = goal << DEF_FRAC_BITS;
      acc  = '0;
      code = '0;
      pat  = '0;
      for (i = NUM_W - 1; i >= 0; i--) begin
         trial = acc + weight_tbl[i];
         if (trial <= {2'b00, goal}) begin
            acc = trial;
            pat[i] = 1'b1;
            code = code | mask_tbl[i];
         end
      end
      r.code_low    = code[23:0];
      r.code_high   = code[47:24];
      r.bit_pattern = pat;
      return r;
   endfunction

   task automatic flag_fault(input string msg);
      if (fault_cnt < REPORT_MAX) begin
         $display("%0t: %s", $realtime, msg);
      end
      fault_cnt++;
   endtask

   always @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_W; i++) begin
            weight_tbl[i] = '0;
            mask_tbl[i] = '0;
         end
         zero_off = '0;
         idle_cycles = 0;
      end else begin
         req_fire = req_valid && !req_stall;
         rsp_fire = rsp_valid && !rsp_stall;
         if (rsp_fire) begin
            if (pending_codes.size() == 0) begin
               flag_fault($sformatf("unexpected item lo %h hi %h pat %h",
                                    rsp_item.code_low, rsp_item.code_high,
                                    rsp_item.bit_pattern));
            end else begin
               want = pending_codes.pop_front();
               if (want.code_low !== rsp_item.code_low ||
                   want.code_high !== rsp_item.code_high ||
                   want.bit_pattern !== rsp_item.bit_pattern) begin
                  flag_fault($sformatf("mismatch: exp lo %h hi %h pat %h, got lo %h hi %h pat %h",
                                       want.code_low, want.code_high, want.bit_pattern,
                                       rsp_item.code_low, rsp_item.code_high,
                                       rsp_item.bit_pattern));
               end
            end
         end
         if (csr_wr_en) begin
            zero_off = csr_wr_data;
         end
         if (req_fire) begin
            case (req_item.action)
               ACT_LOAD_WEIGHT: begin
                  if (req_item.bit_number < NUM_W) begin
                     weight_tbl[req_item.bit_number] = req_item.weight_value;
                  end
               end
               ACT_LOAD_MASK: begin
                  if (req_item.bit_number < NUM_W) begin
                     mask_tbl[req_item.bit_number] = req_item.mask_value;
                  end
               end
               ACT_CONVERT: begin
                  pending_codes.push_back(item_known ? item_rsp
                                                     : map_code(req_item.code_index));
               end
               default: ;
            endcase
         end
         if (req_fire || rsp_fire) begin
            idle_cycles = 0;
         end else begin
            idle_cycles++;
         end
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("Verification failed");
            $finish;
         end
      end
   end

   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
         stall_left <= 0;
      end else if (stall_left != 0) begin
         stall_left <= stall_left - 1;
         rsp_stall <= 1'b1;
      end else if (rsp_idle_on && $urandom_range(0, 4) == 0) begin
         stall_left <= $urandom_range(0, 3);
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   // stall only moves at the rising edge, so the falling edge sees the
   // value that decides the next accept
   task automatic send_item(input req_type it, input logic known, input rsp_type rsp);
      int   gap;
      logic taken;
      if (req_gaps && $urandom_range(0, 3) == 0) begin
         gap = $urandom_range(1, 4);
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_item <= it;
      item_known <= known;
      item_rsp <= rsp;
      do begin
         @(negedge clock);
         taken = !req_stall;
         @(posedge clock);
      end while (!taken);
   endtask

   // drain results, then let any trailing loads leave the chain
   task automatic quiesce();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_codes.size() != 0) @(negedge clock);
      repeat (LATENCY + 4) @(posedge clock);
   endtask

   task automatic write_offset(input logic [INDEX_W-1:0] v);
      quiesce();
      csr_wr_en <= 1'b1;
      csr_wr_data <= v;
      @(posedge clock);
      csr_wr_en <= 1'b0;
   endtask

   function automatic req_type make_req(input logic [ACTION_W-1:0] act,
                                        input logic [BITN_W-1:0] bitn,
                                        input logic [WEIGHT_W-1:0] w);
      req_type    r;
      logic [63:0] wide;
      wide           = {$urandom(), $urandom()};
      r.action       = act;
      r.code_index   = INDEX_W'($urandom());
      r.bit_number   = bitn;
      r.weight_value = w;
      r.mask_value   = wide[MASK_W-1:0];
      case ($urandom_range(0, 7))
         0: r.code_index = '0;
         1: r.code_index = '1;
         default: ;
      endcase
      return r;
   endfunction

   function automatic logic [WEIGHT_W-1:0] pick_weight(input int mode, input int i);
      int jitter;
      jitter = $urandom_range(0, 255);
      case (mode)
         0: return WEIGHT_W'(FIB[i] * 256 + jitter - 128);
         1: return WEIGHT_W'(FIB[i] * 256);
         2: return WEIGHT_W'($urandom());
         default: begin
            if ($urandom_range(0, 3) == 0) begin
               return '0;
            end
            return WEIGHT_W'($urandom_range(0, 2097151) >> (NUM_W - 1 - i));
         end
      endcase
   endfunction

   initial begin
      int          p;
      int          i;
      int          mode;
      int          sel;
      logic [11:0] offs;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      for (i = 0; i < DIR_N; i++) begin
         send_item(DIR_ROWS[i].req, DIR_ROWS[i].known, DIR_ROWS[i].rsp);
      end

      for (p = 0; p < PHASES; p++) begin
         case (p)
            0: offs = 12'd4095;
            1: offs = 12'd0;
            3: offs = 12'($urandom_range(0, 255));
            default: offs = 12'($urandom());
         endcase
         write_offset(offs);
         if (p == PHASES - 1) begin
            req_gaps = 1'b0;
            rsp_idle_on <= 1'b0;
         end else begin
            req_gaps = ($urandom_range(0, 3) != 0);
         end
         mode = (p == 0) ? 0 : $urandom_range(0, 3);
         for (i = 0; i < NUM_W; i++) begin
            send_item(make_req(ACT_LOAD_WEIGHT, BITN_W'(i), pick_weight(mode, i)), 1'b0, NONE);
            send_item(make_req(ACT_LOAD_MASK, BITN_W'(i), pick_weight(mode, i)), 1'b0, NONE);
         end
         for (i = 0; i < MIXED_N; i++) begin
            sel = $urandom_range(0, 99);
            if (sel < 78) begin
               send_item(make_req(ACT_CONVERT, BITN_W'($urandom()), WEIGHT_W'($urandom())),
                         1'b0, NONE);
            end else if (sel < 86) begin
               sel = $urandom_range(0, NUM_W - 1);
               send_item(make_req(ACT_LOAD_WEIGHT, BITN_W'(sel), pick_weight(mode, sel)),
                         1'b0, NONE);
            end else if (sel < 93) begin
               send_item(make_req(ACT_LOAD_MASK, BITN_W'($urandom_range(0, NUM_W - 1)),
                                  WEIGHT_W'($urandom())), 1'b0, NONE);
            end else if (sel < 96) begin
               send_item(make_req(ACT_UNUSED, BITN_W'($urandom()), WEIGHT_W'($urandom())),
                         1'b0, NONE);
            end else begin
               send_item(make_req($urandom_range(0, 1) ? ACT_LOAD_WEIGHT : ACT_LOAD_MASK,
                                  BITN_W'($urandom_range(NUM_W, 31)),
                                  WEIGHT_W'($urandom())), 1'b0, NONE);
            end
         end
      end

      quiesce();
      if (fault_cnt == 0 && pending_codes.size() == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule
